FILE: design/pending_transaction_table_core_macros.svh
// assertion macros used by the pending transaction table core
`ifndef PENDING_TRANSACTION_TABLE_CORE_MACROS_SVH
`define PENDING_TRANSACTION_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pttc_pkg.sv
// shared types and codes of the pending transaction table
package pttc_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_EXPIRE = 2'd3
    } t_mode;

    localparam logic [30:0] AGE_RESET = 31'd10000;

    typedef struct packed {
        logic [31:0] txn;
        logic [7:0]  kind;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] sent;
    } t_entry;

    typedef struct packed {
        logic        match;
        logic        expired;
    } t_cmp;

    typedef struct packed {
        logic        hit;
        logic [4:0]  slot;
        t_entry      ent;
        logic [5:0]  freed;
    } t_result;

endpackage

FILE: design/pending_transaction_table_core.sv
// pending transaction table top level: sequencer, valid bits, result register
// Each item is handled alone, one slot per cycle. Allocate walks the valid bits
// from slot 0 until it takes a free slot or passes the last; find and expire read
// the slot memory through its single registered read port and the one comparator
// (find stops at its first match, expire checks every slot); free clears its bit
// in the transfer cycle. The transfer is taken while idle, the scan state follows
// except for free, and the result register is loaded from the finish state once
// the output is free; the input stays stalled until then. Valid bits are
// flip-flops cleared by reset, so no clearing pass runs.
// The configuration port is always ready; the user is to write it only while idle, as the block does not enforce it.
module pending_transaction_table_core #(
    parameter int SLOTS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pttc_pkg::t_mode     i_mode,
    input  logic [31:0]         i_txn_id,
    input  logic [7:0]          i_expected_kind,
    input  logic [31:0]         i_peer_address,
    input  logic [15:0]         i_peer_port,
    input  logic [4:0]          i_slot_index,
    input  logic [31:0]         i_now_ms,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [30:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic [4:0]          o_slot,
    output logic [31:0]         o_out_txn_id,
    output logic [7:0]          o_out_kind,
    output logic [31:0]         o_out_address,
    output logic [15:0]         o_out_port,
    output logic [31:0]         o_out_sent_ms,
    output logic [5:0]          o_freed_count
);
    import pttc_pkg::*;

    `include "pending_transaction_table_core_macros.svh"

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    t_mode           r_mode, n_mode;
    logic [31:0]     r_txn, n_txn;
    logic [7:0]      r_kind, n_kind;
    logic [31:0]     r_addr, n_addr;
    logic [15:0]     r_port, n_port;
    logic [31:0]     r_now, n_now;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic            r_issue, n_issue;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_cnt, n_cnt;
    t_result         r_res, n_res;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;
    logic [30:0]     r_age, n_age;
    logic [SLOTS-1:0] r_valid, n_valid;

    logic            in_xfer;
    logic            out_free;
    logic            mem_we;
    t_entry          mem_wdata;
    t_entry          mem_rdata;
    t_cmp            cmp_res;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign mem_wdata = '{txn: r_txn, kind: r_kind, addr: r_addr, port: r_port, sent: r_now};

    pttc_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    pttc_cmp u_cmp (
        .i_key   (r_txn),
        .i_now   (r_now),
        .i_age   (r_age),
        .i_entry (mem_rdata),
        .o_res   (cmp_res)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_txn       = r_txn;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_port      = r_port;
        n_now       = r_now;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_age       = r_age;
        n_valid     = r_valid;
        mem_we      = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_age = i_cfg_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_mode  = i_mode;
                    n_txn   = i_txn_id;
                    n_kind  = i_expected_kind;
                    n_addr  = i_peer_address;
                    n_port  = i_peer_port;
                    n_now   = i_now_ms;
                    n_idx   = '0;
                    n_issue = 1'b1;
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                    n_res   = '0;
                    if (i_mode == MODE_FREE) begin
                        if (32'(i_slot_index) < 32'(SLOTS)) begin
                            n_valid[IW'(i_slot_index)] = 1'b0;
                        end
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_mode == MODE_ALLOC) begin
                    if (!r_valid[r_idx]) begin
                        n_valid[r_idx] = 1'b1;
                        mem_we         = 1'b1;
                        n_res.hit      = 1'b1;
                        n_res.slot     = 5'(r_idx);
                        n_res.ent      = mem_wdata;
                        n_state        = ST_FIN;
                    end else if (r_idx == LAST) begin
                        n_state = ST_FIN;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    // read pipeline: issue slot r_idx, check slot r_pidx
                    n_pend = r_issue;
                    n_pidx = r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST) begin
                            n_issue = 1'b0;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                    if (r_pend) begin
                        if (r_mode == MODE_FIND) begin
                            if (r_valid[r_pidx] && cmp_res.match) begin
                                n_res.hit  = 1'b1;
                                n_res.slot = 5'(r_pidx);
                                n_res.ent  = mem_rdata;
                                n_state    = ST_FIN;
                            end else if (r_pidx == LAST) begin
                                n_state = ST_FIN;
                            end
                        end else begin
                            if (r_valid[r_pidx] && cmp_res.expired) begin
                                n_valid[r_pidx] = 1'b0;
                                n_cnt           = r_cnt + CW'(1);
                            end
                            if (r_pidx == LAST) begin
                                n_state = ST_FIN;
                            end
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out.freed = (r_mode == MODE_EXPIRE) ? 6'(r_cnt) : 6'd0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_age       <= AGE_RESET;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_age       <= n_age;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_txn  <= n_txn;
        r_kind <= n_kind;
        r_addr <= n_addr;
        r_port <= n_port;
        r_now  <= n_now;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out.hit;
    assign o_slot        = r_out.slot;
    assign o_out_txn_id  = r_out.ent.txn;
    assign o_out_kind    = r_out.ent.kind;
    assign o_out_address = r_out.ent.addr;
    assign o_out_port    = r_out.ent.port;
    assign o_out_sent_ms = r_out.ent.sent;
    assign o_freed_count = r_out.freed;

    `PTTC_ASSERT_NEXT(a_busy_after_accept, in_xfer, o_in_stall, "input not stalled after transfer")
    `PTTC_ASSERT_NOW(a_write_only_alloc, mem_we, (r_mode == MODE_ALLOC) && (r_state == ST_SCAN), "slot write outside allocate scan")
    `PTTC_ASSERT_NOW(a_miss_zero, o_out_valid && !o_hit, (o_slot == 5'd0) && (o_out_txn_id == 32'd0), "miss result not zero")
    `PTTC_ASSERT_NOW(a_hit_no_count, o_out_valid && o_hit, o_freed_count == 6'd0, "hit result carries a freed count")

endmodule

FILE: design/pttc_mem.sv
// slot contents memory, one write and one registered read port
module pttc_mem #(
    parameter int SLOTS = 32,
    parameter int IW    = 5
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  pttc_pkg::t_entry i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output pttc_pkg::t_entry o_rdata
);
    import pttc_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pttc_cmp.sv
// shared compare unit: id match and wrapping age check
module pttc_cmp (
    input  logic [31:0]      i_key,
    input  logic [31:0]      i_now,
    input  logic [30:0]      i_age,
    input  pttc_pkg::t_entry i_entry,
    output pttc_pkg::t_cmp   o_res
);
    import pttc_pkg::*;

    logic [31:0] age_now;

    always_comb begin
        age_now       = i_now - i_entry.sent;
        o_res.match   = (i_entry.txn == i_key);
        o_res.expired = (age_now > {1'b0, i_age});
    end

endmodule
